>>> rtl/double_fixed_point_converter_unit_defines.svh
// Assertion macros for the double/fixed converter
`ifndef DOUBLE_FIXED_POINT_CONVERTER_UNIT_DEFINES_SVH
`define DOUBLE_FIXED_POINT_CONVERTER_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define DFC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define DFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/dfc_pkg.sv
// ----------------------------------------------------------------------------
// dfc_pkg
// Shared constants and configuration type of the double/fixed converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package dfc_pkg;
    localparam int DFC_DATA_W = 64;
    localparam int DFC_CFG_IDX_W = 2;
    localparam int DFC_CFG_DATA_W = 64;

    localparam logic [DFC_CFG_IDX_W-1:0] REG_WORD_BITS    = 2'd0;
    localparam logic [DFC_CFG_IDX_W-1:0] REG_INTEGER_BITS = 2'd1;
    localparam logic [DFC_CFG_IDX_W-1:0] REG_SIGNED_MODE  = 2'd2;

    localparam logic OP_TO_FIXED  = 1'b0;
    localparam logic OP_TO_DOUBLE = 1'b1;

    typedef struct packed {
        logic [6:0] width;   // effective word width 1..64
        logic [6:0] frac;    // effective fraction bits 0..width
        logic       sgn;
    } t_cfg;
endpackage

>>> rtl/dfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dfc_cfg_regs
// Configuration registers; presents clamped width and fraction count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dfc_cfg_regs
    import dfc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [DFC_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DFC_CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                      o_cfg
);
    logic [6:0] r_word_bits;
    logic [6:0] r_integer_bits;
    logic       r_signed_mode;
    logic [6:0] w_eff;
    logic [6:0] w_int;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_bits    <= 7'd32;
            r_integer_bits <= 7'd16;
            r_signed_mode  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WORD_BITS:    r_word_bits    <= i_cfg_data[6:0];
                REG_INTEGER_BITS: r_integer_bits <= i_cfg_data[6:0];
                REG_SIGNED_MODE:  r_signed_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_word_bits == 7'd0)      w_eff = 7'd1;
        else if (r_word_bits > 7'd64) w_eff = 7'd64;
        else                          w_eff = r_word_bits;
        w_int = (r_integer_bits > w_eff) ? w_eff : r_integer_bits;
        o_cfg.width = w_eff;
        o_cfg.frac  = w_eff - w_int;
        o_cfg.sgn   = r_signed_mode;
    end
endmodule

>>> rtl/dfc_to_fixed.sv
// ----------------------------------------------------------------------------
// dfc_to_fixed
// Binary64 to fixed point, round half away from zero, with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dfc_to_fixed
    import dfc_pkg::*;
(
    input  logic [DFC_DATA_W-1:0] i_x,
    input  t_cfg                  i_cfg,
    output logic [DFC_DATA_W-1:0] o_res,
    output logic                  o_flag
);
    logic        neg;
    logic [10:0] e;
    logic [51:0] m;
    logic [52:0] sig;
    logic signed [12:0] k;
    logic [6:0]  r;
    logic [116:0] sh;
    logic [63:0] mag;
    logic        ovf;
    logic [63:0] mask;
    logic [63:0] half;
    logic [6:0]  kl;

    always_comb begin
        neg  = i_x[63];
        e    = i_x[62:52];
        m    = i_x[51:0];
        mask = ~64'd0 >> (7'd64 - i_cfg.width);
        half = 64'd1 << (i_cfg.width - 7'd1);
        sig  = (e != 11'd0) ? {1'b1, m} : {1'b0, m};
        k    = ((e != 11'd0) ? ($signed({2'b00, e}) - 13'sd1075) : -13'sd1074)
               + $signed({6'd0, i_cfg.frac});
        mag  = 64'd0;
        ovf  = 1'b0;
        r    = 7'd0;
        kl   = 7'd0;
        sh   = 117'd0;
        o_res  = 64'd0;
        o_flag = 1'b0;
        if (e == 11'h7FF) begin
            ovf = 1'b1;
        end else if (sig == 53'd0) begin
            mag = 64'd0;
        end else if (k >= 13'sd64) begin
            ovf = 1'b1;
        end else if (k >= 13'sd0) begin
            kl = k[6:0];
            sh = {64'd0, sig} << kl;
            if (sh[116:64] != 53'd0) ovf = 1'b1;
            else mag = sh[63:0];
        end else if (k <= -13'sd54) begin
            mag = 64'd0;
        end else begin
            r   = 7'(-k);
            sh  = {sig, 64'd0} >> r;
            mag = {11'd0, sh[116:64]} + {63'd0, sh[63]};
        end

        if (e == 11'h7FF && m != 52'd0) begin
            o_res  = 64'd0;
            o_flag = 1'b1;
        end else if (i_cfg.sgn) begin
            if (neg) begin
                if (ovf || mag > half) begin
                    o_res = half; o_flag = 1'b1;
                end else begin
                    o_res = (64'd0 - mag) & mask;
                end
            end else begin
                if (ovf || mag > half - 64'd1) begin
                    o_res = half - 64'd1; o_flag = 1'b1;
                end else begin
                    o_res = mag;
                end
            end
        end else begin
            if (neg && (sig != 53'd0 || e == 11'h7FF)) begin
                o_res = 64'd0; o_flag = 1'b1;
            end else if (ovf || mag > mask) begin
                o_res = mask; o_flag = 1'b1;
            end else begin
                o_res = mag;
            end
        end
    end
endmodule

>>> rtl/dfc_to_double.sv
// ----------------------------------------------------------------------------
// dfc_to_double
// Fixed point to binary64 with round to nearest even.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dfc_to_double
    import dfc_pkg::*;
(
    input  logic [DFC_DATA_W-1:0] i_x,
    input  t_cfg                  i_cfg,
    output logic [DFC_DATA_W-1:0] o_res
);
    logic [63:0] mask;
    logic [63:0] mag;
    logic        sign;
    logic [5:0]  p;
    logic        found;
    logic [63:0] norm;
    logic [53:0] keep;
    logic        rnd;
    logic        sticky;
    logic [6:0]  pe;
    logic [11:0] bexp;

    always_comb begin
        mask = ~64'd0 >> (7'd64 - i_cfg.width);
        mag  = i_x & mask;
        sign = 1'b0;
        if (i_cfg.sgn && mag[6'(i_cfg.width - 7'd1)]) begin
            sign = 1'b1;
            mag  = (64'd0 - mag) & mask;
            if (mag == 64'd0) mag = 64'd1 << (i_cfg.width - 7'd1);
        end
        p = 6'd0;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && mag[i]) begin
                p = 6'(i);
                found = 1'b1;
            end
        end
        norm   = mag << (6'd63 - p);
        keep   = {1'b0, norm[63:11]};
        rnd    = norm[10];
        sticky = norm[9:0] != 10'd0;
        if (rnd && (sticky || keep[0])) keep = keep + 54'd1;
        pe = {1'b0, p};
        if (keep[53]) begin
            keep = keep >> 1;
            pe   = pe + 7'd1;
        end
        bexp = {5'd0, pe} - {5'd0, i_cfg.frac} + 12'd1023;
        if (mag == 64'd0) o_res = 64'd0;
        else o_res = {sign, bexp[10:0], keep[51:0]};
    end
endmodule

>>> rtl/double_fixed_point_converter_unit.sv
// ----------------------------------------------------------------------------
// double_fixed_point_converter_unit
// Converts binary64 to a configurable fixed-point word and back.
// ----------------------------------------------------------------------------
// channel | ports                                   | handshake
// input   | i_start, i_opcode, i_operand_bits        | start && !busy
// result  | o_valid, o_result_bits, o_range_flag     | one-cycle strobe
// config  | i_cfg_valid, i_cfg_index, i_cfg_data     | valid && ready
// One item per cycle; after acceptance the item passes the input register,
// then the result register. o_busy is always low.
// Reset clears the config to 32/16/signed and drops pending strobes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module double_fixed_point_converter_unit
    import dfc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic                      i_opcode,
    input  logic [DFC_DATA_W-1:0]     i_operand_bits,
    output logic                      o_valid,
    output logic [DFC_DATA_W-1:0]     o_result_bits,
    output logic                      o_range_flag,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [DFC_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DFC_CFG_DATA_W-1:0] i_cfg_data
);
    t_cfg                  cfg;
    logic                  r_in_vld;
    logic                  r_op;
    logic [DFC_DATA_W-1:0] r_x;
    logic [DFC_DATA_W-1:0] fx_res;
    logic                  fx_flag;
    logic [DFC_DATA_W-1:0] db_res;
    logic                  r_out_vld;
    logic [DFC_DATA_W-1:0] r_res;
    logic                  r_flag;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    dfc_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= i_start;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= i_opcode;
        r_x   <= i_operand_bits;
        r_res <= (r_op == OP_TO_DOUBLE) ? db_res : fx_res;
        r_flag <= (r_op == OP_TO_DOUBLE) ? 1'b0 : fx_flag;
    end

    dfc_to_fixed u_fx (.i_x(r_x), .i_cfg(cfg), .o_res(fx_res), .o_flag(fx_flag));
    dfc_to_double u_db (.i_x(r_x), .i_cfg(cfg), .o_res(db_res));

    assign o_valid       = r_out_vld;
    assign o_result_bits = r_res;
    assign o_range_flag  = r_flag;
endmodule

>>> rtl/dfc_checker.sv
// ----------------------------------------------------------------------------
// dfc_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_fixed_point_converter_unit_defines.svh"
module dfc_checker
    import dfc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_start,
    input logic                  o_busy,
    input logic                  i_opcode,
    input logic                  o_valid,
    input logic                  o_range_flag
);
    `DFC_ASSERT_NEXT(a_beat_latency, i_clk, i_rst_n, i_start && !o_busy, ##1 o_valid)
    `DFC_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !i_start, ##1 !o_valid)
    `DFC_ASSERT_NEXT(a_double_noflag, i_clk, i_rst_n, i_start && !o_busy && i_opcode, ##1 !o_range_flag)
endmodule

bind double_fixed_point_converter_unit dfc_checker u_dfc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .i_opcode(i_opcode), .o_valid(o_valid), .o_range_flag(o_range_flag)
);
